>>> design/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

`else

`define ASSERT_ALWAYS(label, expr)
`define ASSERT_IMPLY(label, ante, cons)

`endif

`endif

>>> design/lss_pkg.sv
// Shared types, widths and codes for the LIFO stack with search.
// No dependencies; imported by every module of the block.
`default_nettype none

package lss_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int FILL_W      = 5;
    localparam int LIMIT_W     = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    // func codes on the request channel
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    // status codes on the result channel
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic signed [WORD_W-1:0] operand;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value;
        logic [STATUS_W-1:0]      status;
        logic                     found;
        logic [CNT_W-1:0]         fill;
    } res_t;

endpackage

`default_nettype wire

>>> design/lss_front.sv
// Front end: takes requests, decodes func into a command, holds it in a register.
// Depends on lss_pkg.
`default_nettype none

module lss_front
    import lss_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [FUNC_W-1:0]        in_func,
    input  wire logic signed [WORD_W-1:0] in_operand,
    output logic                          cmd_valid,
    input  wire logic                     cmd_ready,
    output cmd_t                          cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    op_t  op_dec;

    always_comb
    begin
        unique case (in_func)
            FUNC_PUSH:   op_dec = OP_PUSH;
            FUNC_POP:    op_dec = OP_POP;
            FUNC_SEARCH: op_dec = OP_SEARCH;
            default:     op_dec = OP_NOP;
        endcase
    end

    assign in_ready = !valid_reg || cmd_ready;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (in_valid && in_ready)
        begin
            valid_next       = 1'b1;
            cmd_next.op      = op_dec;
            cmd_next.operand = in_operand;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

>>> design/lss_queue.sv
// Short command queue decoupling the front end from the stack engine.
// Depends on lss_pkg.
`default_nettype none

module lss_queue
    import lss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  cmd_t      wr_cmd,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output cmd_t      rd_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_wr;
    logic              do_rd;

    assign wr_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/lss_back.sv
// Stack engine: entry memory, fill count, pop read and sequential search scan.
// Depends on lss_pkg; drives the registered result.
`default_nettype none

module lss_back
    import lss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [LIMIT_W-1:0] stack_limit,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  cmd_t                    cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output res_t                    out_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    logic [WORD_W-1:0]        mem [DEPTH];
    logic [WORD_W-1:0]        rd_data_reg;

    state_t                   state_reg,     state_next;
    logic [CNT_W-1:0]         count_reg,     count_next;
    logic [IDX_W-1:0]         idx_reg,       idx_next;
    logic signed [WORD_W-1:0] key_reg,       key_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     out_res_reg,   out_res_next;

    logic                     wr_en;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     take;
    logic                     full;
    logic                     hit;
    logic                     last;
    logic [CNT_W-1:0]         count_dec;

    assign cmd_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take      = cmd_valid && cmd_ready;
    assign full      = (int'(count_reg) >= int'(stack_limit)) || (int'(count_reg) >= DEPTH);
    assign hit       = (rd_data_reg == key_reg);
    assign last      = ((int'(idx_reg) + 1) == int'(count_reg));
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = idx_reg + IDX_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    out_res_next.value  = '0;
                    out_res_next.status = STAT_OK;
                    out_res_next.found  = 1'b0;
                    out_res_next.fill   = count_reg;
                    unique case (cmd.op)
                        OP_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                out_res_next.status = STAT_OVERFLOW;
                            end
                            else
                            begin
                                wr_en             = 1'b1;
                                count_next        = count_reg + CNT_W'(1);
                                out_res_next.fill = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next      = 1'b1;
                                out_res_next.value  = -32'sd1;
                                out_res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_dec;
                                rd_en      = 1'b1;
                                rd_addr    = count_dec[IDX_W-1:0];
                                state_next = ST_POP;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next      = 1'b1;
                                out_res_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                key_next   = cmd.operand;
                                idx_next   = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                out_valid_next      = 1'b1;
                out_res_next.value  = rd_data_reg;
                out_res_next.status = STAT_OK;
                out_res_next.found  = 1'b0;
                out_res_next.fill   = count_reg;
                state_next          = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (hit || last)
                begin
                    out_valid_next      = 1'b1;
                    out_res_next.value  = '0;
                    out_res_next.status = STAT_OK;
                    out_res_next.found  = hit;
                    out_res_next.fill   = count_reg;
                    state_next          = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        out_res_reg <= out_res_next;
    end

    // entry memory: one write port at the fill count, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= cmd.operand;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

`default_nettype wire

>>> design/lifo_stack_with_search.sv
// LIFO stack with search. A request passes the front register and the queue;
// the engine answers push, overflow, underflow, empty search and unused func
// in its result register, reads memory for a pop and compares one entry at a
// time for a search until a hit or the last entry; it takes one command at a time.
// Async active-low reset empties the stack and sets stack_limit to 16; entry
// memory is not cleared, no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module lifo_stack_with_search
    import lss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // configuration: stack_limit
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata,     // [4:0] stack_limit

    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] operand_value
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] func

    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] result_value, [36:32] fill_count
    output logic [2:0]       m_axis_tuser   // [1:0] status, [2] found
);

    logic [LIMIT_W-1:0] stack_limit_reg;

    logic front_valid;
    logic front_ready;
    cmd_t front_cmd;
    logic queue_valid;
    logic queue_ready;
    cmd_t queue_cmd;
    res_t res;

    // Limit register; the user must write it only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            stack_limit_reg <= cfg_wdata;
        end
    end

    // Front end: accept and classify each request.
    lss_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (s_axis_tuser),
        .in_operand (s_axis_tdata),
        .cmd_valid  (front_valid),
        .cmd_ready  (front_ready),
        .cmd        (front_cmd)
    );

    // Two-entry queue lets the front keep taking requests during a scan.
    lss_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_cmd   (queue_cmd)
    );

    // Engine: memory, fill count, pop read and one-entry-per-cycle search.
    lss_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stack_limit (stack_limit_reg),
        .cmd_valid   (queue_valid),
        .cmd_ready   (queue_ready),
        .cmd         (queue_cmd),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_res     (res)
    );

    assign m_axis_tdata = {3'b000, FILL_W'(res.fill), res.value};
    assign m_axis_tuser = {res.found, res.status};

    // fill never passes the stack depth
    `ASSERT_IMPLY(a_fill_bound, m_axis_tvalid, int'(m_axis_tdata[36:32]) <= DEPTH)
    // a match is only reported with ok status
    `ASSERT_IMPLY(a_found_ok, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == STAT_OK)
    // an overflowed push returns a zero word (its fill, not checked, is nonzero or the limit zero)
    `ASSERT_IMPLY(a_ovf_zero, m_axis_tvalid && (m_axis_tuser[1:0] == STAT_OVERFLOW),
                  m_axis_tdata[31:0] == 32'd0)

endmodule

`default_nettype wire
